### hw/rtl/sparse_csr_row_dot_product_core_assert.svh
// Assertion macros shared by the sparse row dot-product RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef SPARSE_CSR_ROW_DOT_PRODUCT_CORE_ASSERT_SVH
`define SPARSE_CSR_ROW_DOT_PRODUCT_CORE_ASSERT_SVH
`ifndef SYNTH
`define CSRDP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CSRDP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSRDP_ASSERT_IMP(lbl, ante, cons, msg)
`define CSRDP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/csrdp_pkg.sv
// Shared types and constants for the sparse row dot-product core.
// No dependencies; used by the interfaces, the MAC unit and the top level.
`default_nettype none
package csrdp_pkg;

  localparam int MAX_ROWS_DEF     = 256;
  localparam int MAX_COLUMNS_DEF  = 256;
  localparam int MAX_NONZEROS_DEF = 1024;

  localparam int DATA_W  = 32;
  localparam int IDX_W   = 10;
  localparam int START_W = 11;
  localparam int COL_W   = 8;
  localparam int FILL_W  = 9;
  localparam int PROD_W  = 2 * DATA_W;
  // A rounded Q16.16 product drops 16 fraction bits of the Q32.32 product.
  localparam int RND_W   = PROD_W - 16;

  typedef enum logic [1:0] {
    CMD_ROW_START = 2'd0,
    CMD_ENTRY     = 2'd1,
    CMD_VECTOR    = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [COL_W-1:0]         column;
    logic signed [DATA_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctl_t;

  typedef struct packed {
    logic idle;
    logic saturated;
  } mac_stat_t;

endpackage
`default_nettype wire

### hw/rtl/csrdp_in_if.sv
// Command channel of the sparse row dot-product core: valid/ready plus payload.
// Depends on csrdp_pkg for field widths and the command type.
`default_nettype none
interface csrdp_in_if
  import csrdp_pkg::*;
();
  logic                      valid;
  logic                      ready;
  cmd_t                      command;
  logic [IDX_W-1:0]          index;
  logic [START_W-1:0]        start_position;
  logic [COL_W-1:0]          entry_column;
  logic signed [DATA_W-1:0]  data_value;

  modport source (output valid, command, index, start_position, entry_column, data_value,
                  input ready);
  modport sink   (input valid, command, index, start_position, entry_column, data_value,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/csrdp_out_if.sv
// Result channel of the sparse row dot-product core: valid/ready plus payload.
// Depends on csrdp_pkg for field widths.
`default_nettype none
interface csrdp_out_if
  import csrdp_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] row_sum;
  logic                     row_out_of_range;
  logic                     saturated;

  modport source (output valid, row_sum, row_out_of_range, saturated, input ready);
  modport sink   (input valid, row_sum, row_out_of_range, saturated, output ready);
endinterface
`default_nettype wire

### hw/rtl/sparse_csr_row_dot_product_core.sv
// Sparse matrix (compressed rows) times dense vector, one row per query, Q16.16.
// Depends on csrdp_pkg, csrdp_in_if, csrdp_out_if, csrdp_mac and the assertion header.
//
// Use: every command arrives as one transfer on in_chan. Row start pointers,
// nonzero entries (value and column) and vector elements are written into
// three on-chip memories; a write produces no result.
// A query names a row and produces exactly one transfer on out_chan: the
// saturated Q16.16 dot product of that row with the vector, a flag for a row
// at or beyond cfg_wdata's filled row count or MAX_ROWS (sum forced to zero),
// and a flag when the sum was clamped to 32 bits.
// Timing: a query of an in-range row keeps in_chan.ready low until its result
// is loaded: both row pointers are read, the walk issues one entry read per
// cycle until it sees the row end, the tail drains (entry read, vector read,
// multiply into the accumulator) and the result register is loaded, which
// drives out_chan from the following cycle. An empty row issues no entry
// reads and an out-of-range query skips the walk. The entry walk, one memory
// read per cycle, sets most of a query's time.
// The result sits in an output register; further writes are accepted while it
// waits, but a query that finishes before the previous result is taken holds
// until out_chan.ready frees the register, so nothing is lost on a stall.
// Reset clears the control state and the filled row count; memory contents
// are not cleared and must be written before they are read.
`default_nettype none
module sparse_csr_row_dot_product_core
  import csrdp_pkg::*;
#(
  parameter int MAX_ROWS     = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS  = MAX_COLUMNS_DEF,
  parameter int MAX_NONZEROS = MAX_NONZEROS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [FILL_W-1:0] cfg_wdata,
  csrdp_in_if.sink               in_chan,
  csrdp_out_if.source            out_chan
);
  `include "sparse_csr_row_dot_product_core_assert.svh"

  // Address widths of the three memories, and widened index views for them.
  localparam int ROW_AW = (MAX_ROWS + 1 > 1) ? $clog2(MAX_ROWS + 1) : 1;
  localparam int ENT_AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int VEC_AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_XW = (ROW_AW > IDX_W) ? ROW_AW : IDX_W;
  localparam int ENT_XW = (ENT_AW > IDX_W) ? ENT_AW : IDX_W;
  localparam int VEC_XW = (VEC_AW > IDX_W) ? VEC_AW : IDX_W;
  localparam int COL_XW = (VEC_AW > COL_W) ? VEC_AW : COL_W;
  // Walk pointer wide enough for a stored start pointer and for MAX_NONZEROS.
  localparam int PTR_NW = $clog2(MAX_NONZEROS + 1);
  localparam int PTR_W  = (PTR_NW > START_W) ? PTR_NW : START_W;
  localparam logic [PTR_W-1:0] PTR_LIMIT = PTR_W'(MAX_NONZEROS);

  // Memories: row pointers, nonzero entries, vector elements.
  logic [START_W-1:0]       row_mem [MAX_ROWS + 1];
  entry_t                   ent_mem [MAX_NONZEROS];
  logic signed [DATA_W-1:0] vec_mem [MAX_COLUMNS];

  state_t state_r, state_nxt;

  logic [FILL_W-1:0] filled_rows_r;
  logic [PTR_W-1:0]  pos_r, pos_nxt;
  logic [PTR_W-1:0]  end_r, end_nxt;
  logic              oor_r, oor_nxt;

  logic in_xfer, is_query, query_oor;
  logic row_we, ent_we, vec_we;
  logic [ROW_XW-1:0] idx_row_x;
  logic [ENT_XW-1:0] idx_ent_x;
  logic [VEC_XW-1:0] idx_vec_x;
  logic [ROW_AW-1:0] row_addr_b, row_addr_e;

  logic [START_W-1:0] rs_b_q, rs_e_q;
  logic [PTR_W-1:0]   ptr_b, ptr_e, ptr_e_clamp;

  logic              issue;
  logic              v1_r, v2_r;
  entry_t            ent_q;
  logic [ENT_AW-1:0] ent_raddr;
  logic [COL_XW-1:0] col_x;
  logic              col_ok;
  logic              colok2_r;
  logic signed [DATA_W-1:0] val2_r;
  logic signed [DATA_W-1:0] vec_q;
  logic signed [DATA_W-1:0] mac_b;

  mac_ctl_t  mac_ctl;
  mac_stat_t mac_stat;
  logic signed [DATA_W-1:0] mac_sum;

  logic pipe_empty, load_out, fetch_step;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_sum_r;
  logic                     out_oor_r, out_sat_r;

  // ---------------------------------------------------------------- input decode
  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign is_query = in_chan.command == CMD_QUERY;

  assign idx_row_x = ROW_XW'(in_chan.index);
  assign idx_ent_x = ENT_XW'(in_chan.index);
  assign idx_vec_x = VEC_XW'(in_chan.index);

  // Writes beyond a store's depth are dropped.
  assign row_we = in_xfer && (in_chan.command == CMD_ROW_START)
                  && (32'(in_chan.index) <= 32'(MAX_ROWS));
  assign ent_we = in_xfer && (in_chan.command == CMD_ENTRY)
                  && (32'(in_chan.index) < 32'(MAX_NONZEROS));
  assign vec_we = in_xfer && (in_chan.command == CMD_VECTOR)
                  && (32'(in_chan.index) < 32'(MAX_COLUMNS));

  assign query_oor = (IDX_W'(filled_rows_r) <= in_chan.index) ||
                     (32'(in_chan.index) >= 32'(MAX_ROWS));

  // Both pointers of the queried row are read at the query's transfer edge;
  // for an in-range row, index + 1 is at most MAX_ROWS.
  assign row_addr_b = idx_row_x[ROW_AW-1:0];
  assign row_addr_e = ROW_AW'(row_addr_b + 1'b1);

  always_ff @(posedge clk) begin
    if (row_we) begin
      row_mem[row_addr_b] <= in_chan.start_position;
    end
    rs_b_q <= row_mem[row_addr_b];
    rs_e_q <= row_mem[row_addr_e];
  end

  // ------------------------------------------------------------------ row walk
  assign ptr_b       = PTR_W'(rs_b_q);
  assign ptr_e       = PTR_W'(rs_e_q);
  assign ptr_e_clamp = (ptr_e > PTR_LIMIT) ? PTR_LIMIT : ptr_e;
  assign ent_raddr   = pos_r[ENT_AW-1:0];

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[idx_ent_x[ENT_AW-1:0]] <= '{column: in_chan.entry_column,
                                          value:  in_chan.data_value};
    end
    ent_q <= ent_mem[ent_raddr];
  end

  // Entry columns beyond the vector multiply by zero.
  assign col_x  = COL_XW'(ent_q.column);
  assign col_ok = 32'(ent_q.column) < 32'(MAX_COLUMNS);

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[idx_vec_x[VEC_AW-1:0]] <= in_chan.data_value;
    end
    vec_q <= vec_mem[col_x[VEC_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    val2_r   <= ent_q.value;
    colok2_r <= col_ok;
  end

  assign mac_b = colok2_r ? vec_q : '0;

  // ------------------------------------------------------------- state machine
  assign pipe_empty = !v1_r && !v2_r && mac_stat.idle;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && is_query) begin
          state_nxt = query_oor ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_WALK;
      ST_WALK: begin
        if (!(pos_r < end_r)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = 1'b0;
    issue         = 1'b0;
    fetch_step    = 1'b0;
    load_out      = 1'b0;
    mac_ctl.clear = 1'b0;
    mac_ctl.valid = v2_r;
    unique case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        mac_ctl.clear = in_xfer && is_query;
      end
      ST_FETCH: fetch_step = 1'b1;
      ST_WALK:  issue      = pos_r < end_r;
      ST_DRAIN: ;
      ST_DONE:  load_out   = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  always_comb begin
    pos_nxt = pos_r;
    end_nxt = end_r;
    oor_nxt = oor_r;
    if (in_xfer && is_query) begin
      oor_nxt = query_oor;
    end
    if (fetch_step) begin
      pos_nxt = ptr_b;
      end_nxt = ptr_e_clamp;
    end else if (issue) begin
      pos_nxt = PTR_W'(pos_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      filled_rows_r <= '0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      oor_r         <= 1'b0;
      pos_r         <= '0;
      end_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        filled_rows_r <= cfg_wdata;
      end
      v1_r  <= issue;
      v2_r  <= v1_r;
      oor_r <= oor_nxt;
      pos_r <= pos_nxt;
      end_r <= end_nxt;
    end
  end

  csrdp_mac #(
    .MAX_NONZEROS(MAX_NONZEROS)
  ) u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mac_ctl),
    .a    (val2_r),
    .b    (mac_b),
    .stat (mac_stat),
    .sum  (mac_sum)
  );

  // ------------------------------------------------------------ result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sum_r <= oor_r ? '0 : mac_sum;
      out_oor_r <= oor_r;
      out_sat_r <= oor_r ? 1'b0 : mac_stat.saturated;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.row_sum          = out_sum_r;
  assign out_chan.row_out_of_range = out_oor_r;
  assign out_chan.saturated        = out_sat_r;

  // ---------------------------------------------------------------- assertions
  `CSRDP_ASSERT_IMP(a_ready_pipe_empty, in_chan.ready, !v1_r && !v2_r, "input taken while the walk is busy")
  `CSRDP_ASSERT_IMP(a_load_no_overwrite, load_out, !out_valid_r || out_chan.ready, "result overwritten")
  `CSRDP_ASSERT_IMP(a_oor_zero, out_chan.valid && out_chan.row_out_of_range, (out_chan.row_sum == '0) && !out_chan.saturated, "out-of-range row with a sum")
  `CSRDP_ASSERT_NXT(a_issue_reaches_mac, v1_r, v2_r, "entry read lost before the multiplier")

endmodule
`default_nettype wire

### hw/rtl/csrdp_mac.sv
// Multiply, round and accumulate unit: registered 32x32 product, then a wide sum.
// Depends on csrdp_pkg and the assertion macro header.
`default_nettype none
module csrdp_mac
  import csrdp_pkg::*;
#(
  parameter int MAX_NONZEROS = MAX_NONZEROS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mac_ctl_t                 ctl,
  input  wire logic signed [DATA_W-1:0] a,
  input  wire logic signed [DATA_W-1:0] b,
  output mac_stat_t                     stat,
  output logic signed [DATA_W-1:0]      sum
);
  `include "sparse_csr_row_dot_product_core_assert.svh"

  // Room for MAX_NONZEROS rounded products without overflow.
  localparam int ACC_W = RND_W + $clog2(MAX_NONZEROS + 1) + 1;
  localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SUM_MIN = ACC_W'(-64'sh0000_0000_8000_0000);

  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r, pv_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [RND_W-1:0]  rnd;
  logic                     over_hi, over_lo;

  // Round half towards plus infinity, then floor shift to Q16.16.
  assign prod_rnd = (prod_r + PROD_W'(64'sd32768)) >>> 16;
  assign rnd      = prod_rnd[RND_W-1:0];

  always_comb begin
    pv_nxt  = ctl.valid;
    acc_nxt = acc_r;
    if (ctl.clear) begin
      pv_nxt  = 1'b0;
      acc_nxt = '0;
    end else if (pv_r) begin
      acc_nxt = acc_r + ACC_W'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      pv_r  <= pv_nxt;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign over_hi        = acc_r > SUM_MAX;
  assign over_lo        = acc_r < SUM_MIN;
  assign stat.idle      = !pv_r;
  assign stat.saturated = over_hi || over_lo;

  always_comb begin
    if (over_hi) begin
      sum = SUM_MAX[DATA_W-1:0];
    end else if (over_lo) begin
      sum = SUM_MIN[DATA_W-1:0];
    end else begin
      sum = acc_r[DATA_W-1:0];
    end
  end

  `CSRDP_ASSERT_NXT(a_clear_zeroes_acc, ctl.clear, (acc_r == '0) && !pv_r, "accumulator not cleared")
  `CSRDP_ASSERT_IMP(a_no_clear_while_busy, ctl.clear, !pv_r, "clear while a product is in flight")

endmodule
`default_nettype wire
